// ===== rtl/core/sssp_pkg.sv =====
package sssp_pkg;

	// Default graph size and the fixed field widths of the item and configuration ports.
	localparam int DEF_MAX_VERTICES = 32;
	localparam int VERTEX_W         = 5;
	localparam int WEIGHT_W         = 16;
	localparam int COUNT_W          = 6;
	localparam int CFG_IDX_W        = 1;
	localparam int CFG_DATA_W       = 6;

	// Weight value that marks a missing edge and an unreachable vertex.
	localparam logic [WEIGHT_W-1:0] NO_EDGE = 16'hFFFF;

	// Configuration register indexes and reset values.
	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_VERTEX = 1'b1;
	localparam logic [COUNT_W-1:0]   VERTEX_COUNT_RESET = 6'd32;
	localparam logic [VERTEX_W-1:0]  SOURCE_VERTEX_RESET = 5'd0;

	// Datapath operation codes issued by the controller.
	localparam logic [2:0] OP_NOP     = 3'd0;
	localparam logic [2:0] OP_WRITE   = 3'd1;
	localparam logic [2:0] OP_INIT    = 3'd2;
	localparam logic [2:0] OP_FIND    = 3'd3;
	localparam logic [2:0] OP_SETTLE  = 3'd4;
	localparam logic [2:0] OP_RELAX   = 3'd5;
	localparam logic [2:0] OP_EMIT_RD = 3'd6;
	localparam logic [2:0] OP_EMIT_LD = 3'd7;

	// Command from the controller to the datapath.
	typedef struct packed {
		logic [2:0] op;
		logic       last;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic found;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== rtl/core/single_source_shortest_path_core.sv =====
// Dijkstra shortest-path engine over an on-chip adjacency matrix of MAX_VERTICES x MAX_VERTICES
// 16-bit weights (65535 means no edge). A write item (command 0) stores one weight in the cycle
// it is taken. A run item (command 1) searches from source_vertex over the first vertex_count
// vertices and then sends one result per vertex in ascending order, with last set on the final
// one; no input item is taken until the last result has been loaded into the output register.
// For n vertices the search first loads the distances from the source row and drains; then,
// for each of up to n rounds, it scans the distance table to find the minimum, drains, settles,
// scans a weight row to relax and drains, each pass through the single read port of its memory.
// The search ends early after a round that finds no reachable open vertex. Each result is then
// read from the tables and loaded into the output register once that register is free, one
// result at a time. The user must write configuration only while the block is idle; the block
// itself does not enforce this.
module single_source_shortest_path_core #(
	parameter int MAX_VERTICES = sssp_pkg::DEF_MAX_VERTICES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [sssp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sssp_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              command,
	input  logic [sssp_pkg::VERTEX_W-1:0]     row_vertex,
	input  logic [sssp_pkg::VERTEX_W-1:0]     col_vertex,
	input  logic [sssp_pkg::WEIGHT_W-1:0]     weight,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [sssp_pkg::VERTEX_W-1:0]     vertex,
	output logic [sssp_pkg::WEIGHT_W-1:0]     distance,
	output logic [sssp_pkg::VERTEX_W-1:0]     predecessor,
	output logic                              last
);
	import sssp_pkg::*;

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int NW = $clog2(MAX_VERTICES + 1);

	logic [COUNT_W-1:0]  vertex_count_q;
	logic [VERTEX_W-1:0] source_vertex_q;
	logic [NW-1:0]       n_eff;
	dp_cmd_t             cmd;
	dp_stat_t            stat;
	logic [VW-1:0]       idx;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q  <= VERTEX_COUNT_RESET;
			source_vertex_q <= SOURCE_VERTEX_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_VERTEX_COUNT:  vertex_count_q  <= cfg_data[COUNT_W-1:0];
				REG_SOURCE_VERTEX: source_vertex_q <= cfg_data[VERTEX_W-1:0];
				default: ;
			endcase
		end
	end

	// Vertex count clamped to the matrix size.
	always_comb begin
		if (32'(vertex_count_q) > MAX_VERTICES) begin
			n_eff = NW'(MAX_VERTICES);
		end else begin
			n_eff = NW'(vertex_count_q);
		end
	end

	sssp_ctrl #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.command  (command),
		.n_eff    (n_eff),
		.stat     (stat),
		.cmd      (cmd),
		.idx      (idx)
	);

	sssp_dpath #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.idx         (idx),
		.src_vertex  (source_vertex_q),
		.row_vertex  (row_vertex),
		.col_vertex  (col_vertex),
		.weight      (weight),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.vertex      (vertex),
		.distance    (distance),
		.predecessor (predecessor),
		.last        (last)
	);

`ifndef SYNTHESIS
	// A run over at least one vertex makes the block busy.
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && command && (n_eff != '0)) |=> in_stall)
		else $error("run item did not start a search");

	// A weight write finishes in the cycle it is taken.
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !command) |=> !in_stall)
		else $error("write item left the block busy");

	// A result appears only while a search is in progress.
	a_result_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result produced without a run");
`endif

endmodule

// ===== rtl/core/sssp_dpath.sv =====
module sssp_dpath #(
	parameter int MAX_VERTICES = sssp_pkg::DEF_MAX_VERTICES
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  sssp_pkg::dp_cmd_t                               cmd,
	input  logic [$clog2(MAX_VERTICES)-1:0]                 idx,
	input  logic [sssp_pkg::VERTEX_W-1:0]                   src_vertex,
	input  logic [sssp_pkg::VERTEX_W-1:0]                   row_vertex,
	input  logic [sssp_pkg::VERTEX_W-1:0]                   col_vertex,
	input  logic [sssp_pkg::WEIGHT_W-1:0]                   weight,
	output sssp_pkg::dp_stat_t                              stat,
	output logic                                            out_valid,
	input  logic                                            out_stall,
	output logic [sssp_pkg::VERTEX_W-1:0]                   vertex,
	output logic [sssp_pkg::WEIGHT_W-1:0]                   distance,
	output logic [sssp_pkg::VERTEX_W-1:0]                   predecessor,
	output logic                                            last
);
	import sssp_pkg::*;

	localparam int VW    = $clog2(MAX_VERTICES);
	localparam int AW    = 2 * VW;
	localparam int DEPTH = MAX_VERTICES * (1 << VW);

	// Storage: weight matrix, distance and predecessor tables, settled flags.
	logic [WEIGHT_W-1:0]     weight_mem [DEPTH];
	logic [WEIGHT_W-1:0]     dist_mem [MAX_VERTICES];
	logic [VW-1:0]           pred_mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] settled_q;

	// Registered read data.
	logic [WEIGHT_W-1:0] w_rd_q;
	logic [WEIGHT_W-1:0] d_rd_q;
	logic [VW-1:0]       p_rd_q;

	// Second stage of a scan: the element whose read data is now present.
	logic [2:0]    op_s1;
	logic [VW-1:0] idx_s1;
	logic          first_s1;

	// Running minimum of the current search round.
	logic [WEIGHT_W-1:0] best_q;
	logic [VW-1:0]       pick_q;
	logic                found_q;

	// Output register.
	logic                out_valid_q;
	logic [VERTEX_W-1:0] vertex_q;
	logic [WEIGHT_W-1:0] distance_q;
	logic [VERTEX_W-1:0] predecessor_q;
	logic                last_q;

	logic                src_ok;
	logic [VW-1:0]       src_idx;
	logic                is_src;
	logic                wr_ok;
	logic [AW-1:0]       w_wr_addr;
	logic [AW-1:0]       w_rd_addr;
	logic                w_rd_en;
	logic                d_rd_en;
	logic [WEIGHT_W:0]   sum;
	logic                relax_hit;
	logic [WEIGHT_W-1:0] base;
	logic                find_hit;
	logic                tbl_we;
	logic [WEIGHT_W-1:0] dist_wd;
	logic [VW-1:0]       pred_wd;
	logic                out_free;

	// Source and write address decoding.
	assign src_ok    = 32'(src_vertex) < MAX_VERTICES;
	assign src_idx   = VW'(src_vertex);
	assign is_src    = src_ok && (idx_s1 == src_idx);
	assign wr_ok     = (32'(row_vertex) < MAX_VERTICES) && (32'(col_vertex) < MAX_VERTICES);
	assign w_wr_addr = {VW'(row_vertex), VW'(col_vertex)};

	// The weight row comes from the source during init and from the pick while relaxing.
	assign w_rd_en   = (cmd.op == OP_INIT) || (cmd.op == OP_RELAX);
	assign w_rd_addr = (cmd.op == OP_INIT) ? {src_idx, idx} : {pick_q, idx};
	assign d_rd_en   = (cmd.op == OP_FIND) || (cmd.op == OP_RELAX) || (cmd.op == OP_EMIT_RD);

	// Weight matrix memory.
	always_ff @(posedge clk) begin
		if (cmd.op == OP_WRITE && wr_ok) begin
			weight_mem[w_wr_addr] <= weight;
		end
		if (w_rd_en) begin
			w_rd_q <= weight_mem[w_rd_addr];
		end
	end

	// Relaxation: the path sum is kept at 17 bits so it never wraps.
	assign sum       = {1'b0, best_q} + {1'b0, w_rd_q};
	assign relax_hit = (op_s1 == OP_RELAX) && !settled_q[idx_s1] && (sum < {1'b0, d_rd_q});

	// Table write data for init and relaxation.
	assign tbl_we  = (op_s1 == OP_INIT) || relax_hit;
	always_comb begin
		if (op_s1 == OP_INIT) begin
			dist_wd = is_src ? '0 : (src_ok ? w_rd_q : NO_EDGE);
			pred_wd = '0;
		end else begin
			dist_wd = sum[WEIGHT_W-1:0];
			pred_wd = pick_q;
		end
	end

	// Distance and predecessor table memories.
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			dist_mem[idx_s1] <= dist_wd;
			pred_mem[idx_s1] <= pred_wd;
		end
		if (d_rd_en) begin
			d_rd_q <= dist_mem[idx];
		end
		if (cmd.op == OP_EMIT_RD) begin
			p_rd_q <= pred_mem[idx];
		end
	end

	// Scan pipeline stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= OP_NOP;
		end else begin
			op_s1 <= cmd.op;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1   <= idx;
		first_s1 <= (idx == '0);
	end

	// Minimum search, lowest index wins on ties.
	assign base     = first_s1 ? NO_EDGE : best_q;
	assign find_hit = (op_s1 == OP_FIND) && !settled_q[idx_s1] && (d_rd_q < base);

	always_ff @(posedge clk) begin
		if (op_s1 == OP_FIND) begin
			best_q <= find_hit ? d_rd_q : base;
			if (find_hit) begin
				pick_q <= idx_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (op_s1 == OP_FIND) begin
			found_q <= find_hit || (!first_s1 && found_q);
		end
	end

	// Settled flags: init marks only the source, settle marks the pick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settled_q <= '0;
		end else begin
			if (op_s1 == OP_INIT) begin
				settled_q[idx_s1] <= is_src;
			end
			if (cmd.op == OP_SETTLE) begin
				settled_q[pick_q] <= 1'b1;
			end
		end
	end

	// Output register: loaded when free or being taken in the same cycle.
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_EMIT_LD) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_EMIT_LD) begin
			vertex_q      <= VERTEX_W'(idx);
			distance_q    <= d_rd_q;
			predecessor_q <= VERTEX_W'(p_rd_q);
			last_q        <= cmd.last;
		end
	end

	assign stat.found    = found_q;
	assign stat.out_free = out_free;
	assign out_valid     = out_valid_q;
	assign vertex        = vertex_q;
	assign distance      = distance_q;
	assign predecessor   = predecessor_q;
	assign last          = last_q;

endmodule

// ===== rtl/core/sssp_ctrl.sv =====
module sssp_ctrl #(
	parameter int MAX_VERTICES = sssp_pkg::DEF_MAX_VERTICES
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                command,
	input  logic [$clog2(MAX_VERTICES+1)-1:0]   n_eff,
	input  sssp_pkg::dp_stat_t                  stat,
	output sssp_pkg::dp_cmd_t                   cmd,
	output logic [$clog2(MAX_VERTICES)-1:0]     idx
);
	import sssp_pkg::*;

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int NW = $clog2(MAX_VERTICES + 1);

	// Controller states.
	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_INIT    = 4'd1;
	localparam logic [3:0] S_DRAIN_I = 4'd2;
	localparam logic [3:0] S_FIND    = 4'd3;
	localparam logic [3:0] S_DRAIN_F = 4'd4;
	localparam logic [3:0] S_SETTLE  = 4'd5;
	localparam logic [3:0] S_RELAX   = 4'd6;
	localparam logic [3:0] S_DRAIN_R = 4'd7;
	localparam logic [3:0] S_EMIT_RD = 4'd8;
	localparam logic [3:0] S_EMIT_LD = 4'd9;

	logic [3:0]    state_q, state_d;
	logic [VW-1:0] idx_q, idx_d;
	logic [VW-1:0] round_q, round_d;
	logic [VW-1:0] last_idx;
	logic          idx_last;
	logic          round_last;

	assign last_idx   = VW'(n_eff - NW'(1));
	assign idx_last   = (idx_q == last_idx);
	assign round_last = (round_q == last_idx);

	// Next state and command decode.
	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		round_d  = round_q;
		cmd.op   = OP_NOP;
		cmd.last = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (!command) begin
						cmd.op = OP_WRITE;
					end else if (n_eff != '0) begin
						state_d = S_INIT;
						idx_d   = '0;
					end
				end
			end
			S_INIT: begin
				cmd.op = OP_INIT;
				if (idx_last) begin
					state_d = S_DRAIN_I;
				end else begin
					idx_d = idx_q + VW'(1);
				end
			end
			S_DRAIN_I: begin
				state_d = S_FIND;
				idx_d   = '0;
				round_d = '0;
			end
			S_FIND: begin
				cmd.op = OP_FIND;
				if (idx_last) begin
					state_d = S_DRAIN_F;
				end else begin
					idx_d = idx_q + VW'(1);
				end
			end
			S_DRAIN_F: begin
				state_d = S_SETTLE;
			end
			S_SETTLE: begin
				idx_d = '0;
				if (stat.found) begin
					cmd.op  = OP_SETTLE;
					state_d = S_RELAX;
				end else begin
					state_d = S_EMIT_RD;
				end
			end
			S_RELAX: begin
				cmd.op = OP_RELAX;
				if (idx_last) begin
					state_d = S_DRAIN_R;
				end else begin
					idx_d = idx_q + VW'(1);
				end
			end
			S_DRAIN_R: begin
				idx_d = '0;
				if (round_last) begin
					state_d = S_EMIT_RD;
				end else begin
					round_d = round_q + VW'(1);
					state_d = S_FIND;
				end
			end
			S_EMIT_RD: begin
				cmd.op  = OP_EMIT_RD;
				state_d = S_EMIT_LD;
			end
			S_EMIT_LD: begin
				if (stat.out_free) begin
					cmd.op   = OP_EMIT_LD;
					cmd.last = idx_last;
					if (idx_last) begin
						state_d = S_IDLE;
					end else begin
						idx_d   = idx_q + VW'(1);
						state_d = S_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and counter registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			round_q <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			round_q <= round_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign idx      = idx_q;

endmodule
